/* design/retry_scheduler_with_backoff_defines.svh */
// Assertion macros for the retry scheduler.
`ifndef RETRY_SCHEDULER_WITH_BACKOFF_DEFINES_SVH
`define RETRY_SCHEDULER_WITH_BACKOFF_DEFINES_SVH
`ifndef SYNTHESIS
`define RSB_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define RSB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
    else $error(msg);
`else
`define RSB_ASSERT_NOW(label, prop, msg)
`define RSB_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* design/rsb_pkg.sv */
`default_nettype none
package rsb_pkg;

  localparam int CMD_W      = 2;
  localparam int NOW_W      = 62;
  localparam int DL_W       = 63;
  localparam int MS_W       = 32;
  localparam int CNT_W      = 32;
  localparam int PERIOD_W   = 17;
  localparam int THRESH_W   = 8;
  localparam int MULT_W     = 11;
  localparam int PMS_W      = 27;
  localparam int PUS_W      = 37;
  localparam int CAPRAW_W   = 38;
  localparam int DELTA_W    = 42;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 3;
  localparam int SETTLE_W   = 2;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SKIP   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CAP_MULT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CAP_MIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CAP_MAX   = 3'd5;

  localparam logic [9:0]  MS_PER_S  = 10'd1000;
  localparam logic [9:0]  US_PER_MS = 10'd1000;
  localparam logic [19:0] US_PER_S  = 20'd1000000;

  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 17'd5;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 8'd2;
  localparam logic [MS_W-1:0]     FLOOR_RST     = 32'd1000;
  localparam logic [MULT_W-1:0]   CAP_MULT_RST  = 11'd16;
  localparam logic [MS_W-1:0]     CAP_MIN_RST   = 32'd60000;
  localparam logic [MS_W-1:0]     CAP_MAX_RST   = 32'd600000;

  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

  typedef struct packed {
    logic [PMS_W-1:0]    per_ms;
    logic [PUS_W-1:0]    period_us;
    logic [THRESH_W-1:0] threshold;
    logic [MS_W-1:0]     floor_ms;
    logic [MS_W-1:0]     cap_ms;
  } cfg_t;

  typedef struct packed {
    logic [MS_W-1:0]  backoff_cur;
    logic [CNT_W-1:0] failure_run;
    logic [CNT_W-1:0] success_count;
    logic [CNT_W-1:0] failure_count;
    logic [CNT_W-1:0] skip_count;
    logic             last_ok;
    logic             attempted;
  } stats_t;

  typedef struct packed {
    logic             upd_deadline;
    logic             skip;
    logic [MS_W-1:0]  wait_ms;
    logic [NOW_W-1:0] now_us;
    stats_t           stats;
  } s1_t;

  typedef struct packed {
    logic               upd_deadline;
    logic [DELTA_W-1:0] delta_us;
    logic [NOW_W-1:0]   now_us;
    stats_t             stats;
  } s2_t;

endpackage
`default_nettype wire

/* design/rsb_in_if.sv */
`default_nettype none
interface rsb_in_if import rsb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [NOW_W-1:0] now_us;
  logic             outcome_ok;

  modport source (output valid, command, now_us, outcome_ok, input ready);
  modport sink (input valid, command, now_us, outcome_ok, output ready);
endinterface
`default_nettype wire

/* design/rsb_out_if.sv */
`default_nettype none
interface rsb_out_if import rsb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             due;
  logic [DL_W-1:0]  next_deadline_us;
  logic [MS_W-1:0]  current_backoff_ms;
  logic [CNT_W-1:0] failure_run;
  logic [CNT_W-1:0] success_count;
  logic [CNT_W-1:0] failure_count;
  logic [CNT_W-1:0] skip_count;
  logic             last_ok;
  logic             attempted;

  modport source (output valid, due, next_deadline_us, current_backoff_ms, failure_run,
                  success_count, failure_count, skip_count, last_ok, attempted,
                  input ready);
  modport sink (input valid, due, next_deadline_us, current_backoff_ms, failure_run,
                success_count, failure_count, skip_count, last_ok, attempted,
                output ready);
endinterface
`default_nettype wire

/* design/rsb_cfg.sv */
`default_nettype none
module rsb_cfg import rsb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg,
  output logic                    cfg_busy
);

  logic [PERIOD_W-1:0] period_r;
  logic [THRESH_W-1:0] threshold_r;
  logic [MS_W-1:0]     floor_r;
  logic [MULT_W-1:0]   cap_mult_r;
  logic [MS_W-1:0]     cap_min_r;
  logic [MS_W-1:0]     cap_max_r;

  logic [PMS_W-1:0]    period_ms_r;
  logic [PUS_W-1:0]    period_us_r;
  logic [CAPRAW_W-1:0] cap_raw_r;
  logic [MS_W-1:0]     cap_r;
  logic [CAPRAW_W-1:0] cap_lo;
  logic [MS_W-1:0]     cap_nxt;

  logic [SETTLE_W-1:0] settle_r;
  logic [SETTLE_W-1:0] settle_nxt;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RST;
      threshold_r <= THRESHOLD_RST;
      floor_r     <= FLOOR_RST;
      cap_mult_r  <= CAP_MULT_RST;
      cap_min_r   <= CAP_MIN_RST;
      cap_max_r   <= CAP_MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PERIOD:    period_r    <= pwdata[PERIOD_W-1:0];
        REG_THRESHOLD: threshold_r <= pwdata[THRESH_W-1:0];
        REG_FLOOR:     floor_r     <= pwdata[MS_W-1:0];
        REG_CAP_MULT:  cap_mult_r  <= pwdata[MULT_W-1:0];
        REG_CAP_MIN:   cap_min_r   <= pwdata[MS_W-1:0];
        REG_CAP_MAX:   cap_max_r   <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PERIOD:    prdata = PDATA_W'(period_r);
      REG_THRESHOLD: prdata = PDATA_W'(threshold_r);
      REG_FLOOR:     prdata = PDATA_W'(floor_r);
      REG_CAP_MULT:  prdata = PDATA_W'(cap_mult_r);
      REG_CAP_MIN:   prdata = PDATA_W'(cap_min_r);
      REG_CAP_MAX:   prdata = PDATA_W'(cap_max_r);
      default:       prdata = '0;
    endcase
  end

  // Three register stages derive the cap: two multiplies, then the clamp.
  assign cap_lo  = (cap_raw_r < CAPRAW_W'(cap_min_r)) ? CAPRAW_W'(cap_min_r) : cap_raw_r;
  assign cap_nxt = (cap_lo > CAPRAW_W'(cap_max_r)) ? cap_max_r : cap_lo[MS_W-1:0];

  always_ff @(posedge clk) begin
    period_ms_r <= PMS_W'(period_r) * PMS_W'(MS_PER_S);
    period_us_r <= PUS_W'(period_r) * PUS_W'(US_PER_S);
    cap_raw_r   <= CAPRAW_W'(period_ms_r) * CAPRAW_W'(cap_mult_r);
    cap_r       <= cap_nxt;
  end

  always_comb begin
    settle_nxt = settle_r;
    if (wr_en) begin
      settle_nxt = SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - SETTLE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign cfg_busy      = (settle_r != '0);
  assign cfg.per_ms    = period_ms_r;
  assign cfg.period_us = period_us_r;
  assign cfg.threshold = threshold_r;
  assign cfg.floor_ms  = floor_r;
  assign cfg.cap_ms    = cap_r;

endmodule
`default_nettype wire

/* design/rsb_backoff.sv */
`default_nettype none
module rsb_backoff import rsb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rsb_in_if.sink    in_if,
  input  wire cfg_t cfg,
  input  wire logic cfg_busy,
  output s1_t       s1,
  output logic      s1_valid,
  input  wire logic s1_ready
);

  logic             v0_r;
  logic             v0_nxt;
  logic [CMD_W-1:0] cmd0_r;
  logic [NOW_W-1:0] now0_r;
  logic             ok0_r;

  logic v1_r;
  logic v1_nxt;
  s1_t  s1_r;
  s1_t  s1_nxt;

  logic [MS_W-1:0]  backoff_r;
  logic [CNT_W-1:0] run_r;
  logic [CNT_W-1:0] succ_r;
  logic [CNT_W-1:0] fail_r;
  logic [CNT_W-1:0] skips_r;
  logic             last_r;
  logic             tried_r;

  logic [MS_W-1:0]  backoff_nxt;
  logic [CNT_W-1:0] run_nxt;
  logic [CNT_W-1:0] succ_nxt;
  logic [CNT_W-1:0] fail_nxt;
  logic [CNT_W-1:0] skips_nxt;
  logic             last_nxt;
  logic             tried_nxt;

  logic rdy0;
  logic rdy1;
  logic in_acc;
  logic take1;

  logic [CNT_W-1:0] run_inc;
  logic             grow;
  logic [MS_W:0]    base;
  logic [MS_W:0]    floored;
  logic [MS_W-1:0]  grown;
  logic [MS_W-1:0]  period_ext;
  logic [MS_W-1:0]  wait_ms;

  assign rdy1        = !v1_r || s1_ready;
  assign rdy0        = !v0_r || rdy1;
  assign in_if.ready = rdy0 && !cfg_busy;
  assign in_acc      = in_if.valid && in_if.ready;
  assign take1       = v0_r && rdy1;
  assign v0_nxt      = in_acc || (v0_r && !rdy1);
  assign v1_nxt      = take1 || (v1_r && !s1_ready);

  assign period_ext = MS_W'(cfg.per_ms);
  assign run_inc    = run_r + CNT_W'(1);
  assign grow       = (run_inc >= CNT_W'(cfg.threshold));
  assign base       = (backoff_r != '0) ? {backoff_r, 1'b0} : {period_ext, 1'b0};
  assign floored    = (base < (MS_W+1)'(cfg.floor_ms)) ? (MS_W+1)'(cfg.floor_ms) : base;
  assign grown      = (floored > (MS_W+1)'(cfg.cap_ms)) ? cfg.cap_ms : floored[MS_W-1:0];

  always_comb begin
    backoff_nxt = backoff_r;
    run_nxt     = run_r;
    succ_nxt    = succ_r;
    fail_nxt    = fail_r;
    skips_nxt   = skips_r;
    last_nxt    = last_r;
    tried_nxt   = tried_r;
    wait_ms     = period_ext;
    if (take1) begin
      if (cmd0_r == CMD_REPORT) begin
        tried_nxt = 1'b1;
        last_nxt  = ok0_r;
        if (ok0_r) begin
          succ_nxt    = succ_r + CNT_W'(1);
          run_nxt     = '0;
          backoff_nxt = '0;
        end else begin
          fail_nxt = fail_r + CNT_W'(1);
          run_nxt  = run_inc;
          if (grow) begin
            backoff_nxt = grown;
          end
          if (backoff_nxt > period_ext) begin
            wait_ms = backoff_nxt;
          end
        end
      end else if (cmd0_r == CMD_SKIP) begin
        skips_nxt = skips_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    s1_nxt.upd_deadline        = (cmd0_r == CMD_REPORT) || (cmd0_r == CMD_SKIP);
    s1_nxt.skip                = (cmd0_r == CMD_SKIP);
    s1_nxt.wait_ms             = wait_ms;
    s1_nxt.now_us              = now0_r;
    s1_nxt.stats.backoff_cur   = backoff_nxt;
    s1_nxt.stats.failure_run   = run_nxt;
    s1_nxt.stats.success_count = succ_nxt;
    s1_nxt.stats.failure_count = fail_nxt;
    s1_nxt.stats.skip_count    = skips_nxt;
    s1_nxt.stats.last_ok       = last_nxt;
    s1_nxt.stats.attempted     = tried_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      backoff_r <= '0;
      run_r     <= '0;
      succ_r    <= '0;
      fail_r    <= '0;
      skips_r   <= '0;
      last_r    <= 1'b0;
      tried_r   <= 1'b0;
    end else begin
      v0_r      <= v0_nxt;
      v1_r      <= v1_nxt;
      backoff_r <= backoff_nxt;
      run_r     <= run_nxt;
      succ_r    <= succ_nxt;
      fail_r    <= fail_nxt;
      skips_r   <= skips_nxt;
      last_r    <= last_nxt;
      tried_r   <= tried_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd0_r <= in_if.command;
      now0_r <= in_if.now_us;
      ok0_r  <= in_if.outcome_ok;
    end
    if (take1) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1       = s1_r;
  assign s1_valid = v1_r;

endmodule
`default_nettype wire

/* design/rsb_deadline.sv */
`default_nettype none
module rsb_deadline import rsb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire s1_t  s1,
  input  wire logic s1_valid,
  output logic      s1_ready,
  rsb_out_if.source out_if
);

  logic v2_r;
  logic v2_nxt;
  s2_t  s2_r;
  s2_t  s2_nxt;

  logic v3_r;
  logic v3_nxt;
  logic            due_r;
  logic [DL_W-1:0] dl_out_r;
  stats_t          stats_r;

  logic [DL_W-1:0] deadline_r;
  logic [DL_W-1:0] sum_us;
  logic [DL_W-1:0] dl_nxt;
  logic            due_nxt;

  logic rdy2;
  logic rdy3;
  logic take2;
  logic take3;

  assign rdy3     = !v3_r || out_if.ready;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;
  assign take2    = s1_valid && rdy2;
  assign take3    = v2_r && rdy3;
  assign v2_nxt   = take2 || (v2_r && !rdy3);
  assign v3_nxt   = take3 || (v3_r && !out_if.ready);

  always_comb begin
    s2_nxt.upd_deadline = s1.upd_deadline;
    s2_nxt.now_us       = s1.now_us;
    s2_nxt.stats        = s1.stats;
    if (s1.skip) begin
      s2_nxt.delta_us = DELTA_W'(cfg.period_us);
    end else begin
      s2_nxt.delta_us = DELTA_W'(s1.wait_ms) * DELTA_W'(US_PER_MS);
    end
  end

  assign sum_us  = {1'b0, s2_r.now_us} + DL_W'(s2_r.delta_us);
  assign dl_nxt  = s2_r.upd_deadline ? sum_us : deadline_r;
  assign due_nxt = (dl_nxt == '0) || ({1'b0, s2_r.now_us} >= dl_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      deadline_r <= '0;
    end else begin
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      if (take3) begin
        deadline_r <= dl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2) begin
      s2_r <= s2_nxt;
    end
    if (take3) begin
      due_r    <= due_nxt;
      dl_out_r <= dl_nxt;
      stats_r  <= s2_r.stats;
    end
  end

  assign out_if.valid              = v3_r;
  assign out_if.due                = due_r;
  assign out_if.next_deadline_us   = dl_out_r;
  assign out_if.current_backoff_ms = stats_r.backoff_cur;
  assign out_if.failure_run        = stats_r.failure_run;
  assign out_if.success_count      = stats_r.success_count;
  assign out_if.failure_count      = stats_r.failure_count;
  assign out_if.skip_count         = stats_r.skip_count;
  assign out_if.last_ok            = stats_r.last_ok;
  assign out_if.attempted          = stats_r.attempted;

endmodule
`default_nettype wire

/* design/retry_scheduler_with_backoff.sv */
// Capped exponential backoff scheduler for one destination. One transaction on the input
// channel (query, outcome report or offline skip, with the current time in microseconds)
// yields exactly one result transaction carrying the due flag, the new deadline and all
// counters. The block takes one transaction per clock cycle unless back-pressure or a register
// update holds the input off; each result passes through a four-stage pipeline (input
// register, backoff update, microsecond scaling, deadline add and compare) in which each
// stage holds its item on back-pressure, so up to four transactions may be in flight while
// a result waits to be taken. Writing any register, and leaving reset, hold the input off
// while the period and backoff cap derived from the registers are recomputed through
// registered multipliers.
`default_nettype none
`include "retry_scheduler_with_backoff_defines.svh"
module retry_scheduler_with_backoff import rsb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  rsb_in_if.sink                  in_if,
  rsb_out_if.source               out_if,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t cfg;
  logic cfg_busy;
  s1_t  s1;
  logic s1_valid;
  logic s1_ready;

  rsb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .cfg_busy (cfg_busy)
  );

  rsb_backoff u_backoff (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg      (cfg),
    .cfg_busy (cfg_busy),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready)
  );

  rsb_deadline u_deadline (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .out_if   (out_if)
  );

  `RSB_ASSERT_NEXT(a_cfg_write_blocks_input, psel && penable && pwrite, !in_if.ready, "input accepted straight after a register write")
  `RSB_ASSERT_NOW(a_not_due_has_deadline, out_if.valid && !out_if.due |-> out_if.next_deadline_us != '0, "result not due without a deadline")
  `RSB_ASSERT_NOW(a_untried_is_clean, out_if.valid && !out_if.attempted |-> !out_if.last_ok && out_if.success_count == '0 && out_if.failure_count == '0, "outcome state set before any report")

endmodule
`default_nettype wire
